@@ design/iost_pkg.sv @@
`default_nettype none
package iost_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_ADD_MPID = 3'd1,
    OP_EXECUTE  = 3'd2,
    OP_CANCEL   = 3'd3,
    OP_DELETE   = 3'd4,
    OP_REPLACE  = 3'd5,
    OP_SYSTEM   = 3'd6
  } op_t;

  localparam logic [3:0] UT_SNAP_START = 4'd6;
  localparam logic [3:0] UT_SNAP_CLEAR = 4'd7;
  localparam logic [3:0] UT_SNAP_END   = 4'd8;

  localparam logic [15:0] TICKER_NONE = 16'hFFFF;

  localparam logic [1:0] REG_SNAP_START = 2'd0;
  localparam logic [1:0] REG_SNAP_CLEAR = 2'd1;
  localparam logic [1:0] REG_SNAP_END   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_REPL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        side_buy;
    logic [31:0] price;
    logic [31:0] qty;
    logic [63:0] new_ref;
    logic [63:0] ord_ref;
    logic [15:0] locate;
    logic [2:0]  operation;
  } msg_t;

  typedef struct packed {
    logic [31:0] tracked_orders;
    logic [15:0] ticker;
    logic [63:0] out_new_ref;
    logic [63:0] out_ord_ref;
    logic [31:0] out_qty;
    logic [31:0] out_price;
    logic        out_side_buy;
    logic [3:0]  update_type;
    logic        accepted;
  } result_t;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
  } entry_t;

endpackage
`default_nettype wire

@@ design/iost_table.sv @@
`default_nettype none
module iost_table #(
  parameter longint DEPTH = 16384,
  parameter int     AW    = 14
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire iost_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output iost_pkg::entry_t     rdata
);
  import iost_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/itch_order_state_tracker.sv @@
`default_nettype none
// Channel    Direction  Width  Contents
// s_axis     in         216    one parsed order message
// m_axis     out        248    one result per message
// cfg        in         16     snapshot marker locates, write only
//
// Each message passes through these steps: accept and table read,
// lookup and write, second write for a replace, result load.
// The single write port of the order table is why a replace needs its second write.
// After reset a clearing pass writes every table entry, one per cycle; no
// message is accepted meanwhile.
// A stalled result holds in the output register while the next message
// may be accepted; it waits only at result load.
module itch_order_state_tracker #(
  parameter int TICKERS         = 16,
  parameter int REFS_PER_TICKER = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // operation, locate, order reference, new_ref, qty, price, side_buy, zero fill
  input  wire logic [215:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // accepted, update_type, out_side_buy, out_price, out_qty, out order reference,
  // out_new_ref, ticker, tracked_orders, zero fill
  output logic [247:0]      m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata
);
  import iost_pkg::*;

  localparam longint DEPTH = longint'(TICKERS) * longint'(REFS_PER_TICKER);
  localparam int     AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t        state, state_next;
  msg_t          in_msg, msg;
  entry_t        rd, wdata, look_wdata;
  result_t       res, look_res;
  logic          we, look_we;
  logic [AW-1:0] waddr, raddr, clr_cnt, idx_in, idx, nidx;
  logic [31:0]   count, look_count;
  logic [15:0]   snap_start, snap_clear, snap_end;
  logic          ok_loc, ok_ref, ok_new, accept;

  assign in_msg = s_axis_tdata[$bits(msg_t)-1:0];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign idx_in = AW'(AW'(in_msg.locate) * AW'(REFS_PER_TICKER) + AW'(in_msg.ord_ref));
  assign idx    = AW'(AW'(msg.locate) * AW'(REFS_PER_TICKER) + AW'(msg.ord_ref));
  assign nidx   = AW'(AW'(msg.locate) * AW'(REFS_PER_TICKER) + AW'(msg.new_ref));
  assign ok_loc = {1'b0, msg.locate} < 17'(TICKERS);
  assign ok_ref = msg.ord_ref < 64'(REFS_PER_TICKER);
  assign ok_new = msg.new_ref < 64'(REFS_PER_TICKER);

  iost_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  always_comb begin
    look_res                = '0;
    look_res.tracked_orders = count;
    look_count              = count;
    look_we                 = 1'b0;
    look_wdata              = '0;
    if (msg.operation >= OP_SYSTEM) begin
      look_res.update_type = 4'd0;
    end else if (msg.operation == OP_DELETE && msg.locate == snap_start) begin
      look_res.accepted    = 1'b1;
      look_res.update_type = UT_SNAP_START;
      look_res.out_ord_ref = msg.ord_ref;
      look_res.ticker      = TICKER_NONE;
    end else if (msg.operation == OP_DELETE && msg.locate == snap_clear) begin
      look_res.accepted    = 1'b1;
      look_res.update_type = UT_SNAP_CLEAR;
      look_res.out_ord_ref = msg.ord_ref;
      look_res.ticker      = msg.ord_ref[15:0];
    end else if (msg.operation == OP_DELETE && msg.locate == snap_end) begin
      look_res.accepted    = 1'b1;
      look_res.update_type = UT_SNAP_END;
      look_res.out_ord_ref = msg.ord_ref;
      look_res.ticker      = TICKER_NONE;
    end else begin
      look_res.update_type = {1'b0, msg.operation};
      if (ok_loc && ok_ref) begin
        if (msg.operation == OP_ADD || msg.operation == OP_ADD_MPID) begin
          look_we    = 1'b1;
          look_wdata = '{side: msg.side_buy, price: msg.price, qty: msg.qty};
          look_count = count + 32'd1;
          look_res.accepted     = 1'b1;
          look_res.out_side_buy = msg.side_buy;
          look_res.out_price    = msg.price;
          look_res.out_qty      = msg.qty;
          look_res.out_ord_ref  = msg.ord_ref;
          look_res.ticker       = msg.locate;
        end else if (rd.qty != 32'd0 && (msg.operation != OP_REPLACE || ok_new)) begin
          look_we               = 1'b1;
          look_res.accepted     = 1'b1;
          look_res.out_side_buy = rd.side;
          look_res.out_price    = rd.price;
          look_res.out_ord_ref  = msg.ord_ref;
          look_res.ticker       = msg.locate;
          look_wdata            = '{side: rd.side, price: rd.price, qty: 32'd0};
          case (msg.operation)
            OP_EXECUTE, OP_CANCEL: begin
              look_res.out_qty = msg.qty;
              if (msg.operation == OP_EXECUTE) begin
                look_res.out_new_ref = msg.new_ref;
              end
              if (msg.qty >= rd.qty) begin
                look_count = count - 32'd1;
              end else begin
                look_wdata.qty = rd.qty - msg.qty;
              end
            end
            OP_DELETE: begin
              look_count = count - 32'd1;
            end
            default: begin
              look_res.out_price   = msg.price;
              look_res.out_qty     = msg.qty;
              look_res.out_new_ref = msg.new_ref;
            end
          endcase
        end
      end
    end
    look_res.tracked_orders = look_count;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_LOOK;
      ST_LOOK: begin
        if (look_we && look_res.update_type == {1'b0, OP_REPLACE}) begin
          state_next = ST_REPL;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_REPL:  state_next = ST_EMIT;
      ST_EMIT:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    we            = 1'b0;
    waddr         = idx;
    wdata         = look_wdata;
    raddr         = idx_in;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_LOOK:  we = look_we;
      ST_REPL: begin
        we    = 1'b1;
        waddr = nidx;
        wdata = '{side: res.out_side_buy, price: msg.price, qty: msg.qty};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
      snap_start    <= 16'hFFFF;
      snap_clear    <= 16'hFFFE;
      snap_end      <= 16'hFFFD;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == ST_LOOK) begin
        count <= look_count;
      end
      if (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_SNAP_START: snap_start <= cfg_wdata;
          REG_SNAP_CLEAR: snap_clear <= cfg_wdata;
          REG_SNAP_END:   snap_end   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg <= in_msg;
    end
    if (state == ST_LOOK) begin
      res <= look_res;
    end
    if (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {2'b00, res};
    end
  end

endmodule
`default_nettype wire

@@ design/iost_checker.sv @@
`default_nettype none
module iost_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [247:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second message taken while one is in progress");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |->
      m_axis_tdata[5] == 1'b0 && m_axis_tdata[69:6] == 64'd0 &&
      m_axis_tdata[197:70] == 128'd0 && m_axis_tdata[213:198] == 16'd0)
    else $error("rejected result carries payload");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("activity right after reset");

endmodule

bind itch_order_state_tracker iost_checker u_iost_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ test/iost_checker.sv @@
`timescale 1ns / 100ps
module iost_scoreboard
  import iost_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [215:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [247:0] m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata,
  output int                errors,
  output int                pending
);

  localparam int TICKERS = 16;
  localparam int REFS = 1024;

  logic [31:0] book_qty [TICKERS*REFS];
  logic [31:0] book_price [TICKERS*REFS];
  logic        book_side [TICKERS*REFS];
  logic [31:0] live_orders;
  logic [15:0] start_loc, clear_loc, end_loc;
  result_t     expected_updates[$];

  initial begin
    errors = 0;
    for (int i = 0; i < TICKERS*REFS; i++) book_qty[i] = '0;
  end

  assign pending = expected_updates.size();

  function automatic result_t rejected(logic [3:0] ut);
    result_t r;
    r = '0;
    r.update_type = ut;
    r.tracked_orders = live_orders;
    return r;
  endfunction

  function automatic result_t track_order(msg_t m);
    result_t r;
    int slot, nslot;
    logic [3:0] op4;
    r = '0;
    op4 = {1'b0, m.operation};
    if (m.operation > OP_REPLACE) return rejected(4'd0);
    if (m.operation == OP_DELETE) begin
      r.accepted = 1'b1;
      r.out_ord_ref = m.ord_ref;
      r.tracked_orders = live_orders;
      if (m.locate == start_loc) begin
        r.update_type = UT_SNAP_START;
        r.ticker = TICKER_NONE;
        return r;
      end
      if (m.locate == clear_loc) begin
        r.update_type = UT_SNAP_CLEAR;
        r.ticker = m.ord_ref[15:0];
        return r;
      end
      if (m.locate == end_loc) begin
        r.update_type = UT_SNAP_END;
        r.ticker = TICKER_NONE;
        return r;
      end
      r = '0;
    end
    if (m.locate >= TICKERS || m.ord_ref >= REFS) return rejected(op4);
    slot = m.locate * REFS + int'(m.ord_ref);
    if (m.operation == OP_ADD || m.operation == OP_ADD_MPID) begin
      book_qty[slot] = m.qty;
      book_price[slot] = m.price;
      book_side[slot] = m.side_buy;
      live_orders++;
      r.accepted = 1'b1;
      r.update_type = op4;
      r.out_side_buy = m.side_buy;
      r.out_price = m.price;
      r.out_qty = m.qty;
      r.out_ord_ref = m.ord_ref;
      r.ticker = m.locate;
      r.tracked_orders = live_orders;
      return r;
    end
    if (book_qty[slot] == 0) return rejected(op4);
    if (m.operation == OP_REPLACE && m.new_ref >= REFS) return rejected(op4);
    r.accepted = 1'b1;
    r.update_type = op4;
    r.out_side_buy = book_side[slot];
    r.out_price = book_price[slot];
    r.out_ord_ref = m.ord_ref;
    r.ticker = m.locate;
    case (m.operation)
      OP_EXECUTE, OP_CANCEL: begin
        if (m.qty >= book_qty[slot]) begin
          book_qty[slot] = '0;
          live_orders--;
        end else begin
          book_qty[slot] = book_qty[slot] - m.qty;
        end
        r.out_qty = m.qty;
        if (m.operation == OP_EXECUTE) r.out_new_ref = m.new_ref;
      end
      OP_DELETE: begin
        book_qty[slot] = '0;
        live_orders--;
      end
      default: begin
        nslot = m.locate * REFS + int'(m.new_ref);
        book_qty[slot] = '0;
        book_qty[nslot] = m.qty;
        book_price[nslot] = m.price;
        book_side[nslot] = r.out_side_buy;
        r.out_price = m.price;
        r.out_qty = m.qty;
        r.out_new_ref = m.new_ref;
      end
    endcase
    r.tracked_orders = live_orders;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      live_orders <= '0;
      start_loc <= 16'hFFFF;
      clear_loc <= 16'hFFFE;
      end_loc <= 16'hFFFD;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SNAP_START: start_loc <= cfg_wdata;
          REG_SNAP_CLEAR: clear_loc <= cfg_wdata;
          REG_SNAP_END: end_loc <= cfg_wdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_updates.push_back(track_order(msg_t'(s_axis_tdata[211:0])));
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[245:0]);
        if (expected_updates.size() == 0) begin
          $display("%0t unexpected transfer, expected none actual %h", $time, got);
          errors++;
        end else begin
          want = expected_updates.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(got.accepted));
          check_field("update_type", 64'(want.update_type), 64'(got.update_type));
          check_field("side", 64'(want.out_side_buy), 64'(got.out_side_buy));
          check_field("price", 64'(want.out_price), 64'(got.out_price));
          check_field("qty", 64'(want.out_qty), 64'(got.out_qty));
          check_field("ord_ref", want.out_ord_ref, got.out_ord_ref);
          check_field("new_ref", want.out_new_ref, got.out_new_ref);
          check_field("ticker", 64'(want.ticker), 64'(got.ticker));
          check_field("tracked_orders", 64'(want.tracked_orders),
                      64'(got.tracked_orders));
        end
      end
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import iost_pkg::*;

  localparam logic [2:0] OP_UNDEFINED = 3'd7;
  localparam int LIMIT = 600000;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [215:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [247:0] m_axis_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [15:0]  cfg_wdata;
  int           errors, pending, cycles;
  logic         hold_req;
  logic [15:0]  snap_start, snap_clear, snap_end;

  itch_order_state_tracker dut (.*);

  iost_scoreboard chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Receiver: ready pattern is re-drawn at random from three modes, with one long hold-off.
  initial begin
    int mode, left, hold_left;
    bit hold_done;
    m_axis_tready = 0;
    mode = 0;
    left = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = 64;
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send(msg_t m);
    s_axis_tdata <= {4'b0, m};
    s_axis_tvalid <= 1'b1;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic pause(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_markers(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    cfg_we <= 1'b1;
    cfg_addr <= REG_SNAP_START;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_addr <= REG_SNAP_CLEAR;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_addr <= REG_SNAP_END;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    snap_start = a;
    snap_clear = b;
    snap_end = c;
  endtask

  function automatic msg_t mk(logic [2:0] op, logic [15:0] loc, logic [63:0] oref,
                              logic [63:0] nref, logic [31:0] q, logic [31:0] p,
                              logic s);
    msg_t m;
    m.operation = op;
    m.locate = loc;
    m.ord_ref = oref;
    m.new_ref = nref;
    m.qty = q;
    m.price = p;
    m.side_buy = s;
    return m;
  endfunction

  function automatic msg_t random_order();
    msg_t m;
    int pick;
    m.locate = 16'($urandom_range(0, 3));
    m.ord_ref = 64'($urandom_range(0, 15));
    m.new_ref = 64'($urandom_range(0, 15));
    m.qty = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 1000);
    m.price = $urandom;
    m.side_buy = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 25) m.operation = OP_ADD;
    else if (pick < 35) m.operation = OP_ADD_MPID;
    else if (pick < 50) m.operation = OP_EXECUTE;
    else if (pick < 63) m.operation = OP_CANCEL;
    else if (pick < 78) m.operation = OP_DELETE;
    else if (pick < 92) m.operation = OP_REPLACE;
    else if (pick < 94) m.operation = OP_SYSTEM;
    else if (pick < 95) m.operation = OP_UNDEFINED;
    else begin
      m.operation = 3'($urandom_range(0, 7));
      m.locate = 16'($urandom);
      m.ord_ref = {$urandom, $urandom};
      m.new_ref = {$urandom, $urandom};
      m.qty = $urandom;
      if ($urandom_range(0, 1)) m.locate = 16'(m.locate[3:0]);
      if ($urandom_range(0, 1)) m.ord_ref = 64'(m.ord_ref[9:0]);
    end
    if (m.operation == OP_EXECUTE) m.new_ref = {$urandom, $urandom};
    if (m.operation == OP_ADD && $urandom_range(0, 30) == 0) m.qty = '0;
    if (m.operation == OP_REPLACE && $urandom_range(0, 20) == 0) m.qty = '0;
    if (m.operation == OP_REPLACE && $urandom_range(0, 20) == 0)
      m.new_ref = {$urandom, $urandom};
    if (m.operation == OP_DELETE && $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: m.locate = snap_start;
        1: m.locate = snap_clear;
        default: m.locate = snap_end;
      endcase
      m.ord_ref = {$urandom, $urandom};
    end
    return m;
  endfunction

  task automatic random_phase(int n, bit with_hold);
    int sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && sent < n) begin
        send(random_order());
        sent++;
        burst--;
        if (with_hold && sent == 40) hold_req = 1;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst = 1;
    hold_req = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    snap_start = 16'hFFFF;
    snap_clear = 16'hFFFE;
    snap_end = 16'hFFFD;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(mk(OP_ADD, 16'd15, 64'd1023, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send(mk(OP_EXECUTE, 16'd15, 64'd1023, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 32'd0, 1'b0));
    send(mk(OP_CANCEL, 16'd15, 64'd1023, 64'd0, 32'd7, 32'd0, 1'b0));
    send(mk(OP_REPLACE, 16'd15, 64'd1023, 64'd0, 32'd50, 32'd123, 1'b0));
    send(mk(OP_REPLACE, 16'd15, 64'd0, 64'd0, 32'd60, 32'd321, 1'b0));
    send(mk(OP_EXECUTE, 16'd15, 64'd0, 64'd9, 32'hFFFF_FFFF, 32'd0, 1'b0));
    send(mk(OP_EXECUTE, 16'd15, 64'd0, 64'd9, 32'd1, 32'd0, 1'b0));
    send(mk(OP_ADD_MPID, 16'd0, 64'd0, 64'd0, 32'd10, 32'd0, 1'b0));
    send(mk(OP_ADD, 16'd0, 64'd0, 64'd0, 32'd20, 32'd77, 1'b1));
    send(mk(OP_DELETE, 16'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0));
    send(mk(OP_DELETE, 16'd0, 64'd0, 64'd0, 32'd0, 32'd0, 1'b0));
    send(mk(OP_ADD, 16'd1, 64'd5, 64'd0, 32'd0, 32'd1, 1'b1));
    send(mk(OP_CANCEL, 16'd1, 64'd5, 64'd0, 32'd1, 32'd0, 1'b0));
    send(mk(OP_ADD, 16'd16, 64'd5, 64'd0, 32'd3, 32'd1, 1'b1));
    send(mk(OP_ADD, 16'd1, 64'd1024, 64'd0, 32'd3, 32'd1, 1'b1));
    send(mk(OP_ADD, 16'd2, 64'd3, 64'd0, 32'd3, 32'd4, 1'b0));
    send(mk(OP_REPLACE, 16'd2, 64'd3, 64'd1024, 32'd3, 32'd4, 1'b0));
    send(mk(OP_REPLACE, 16'd2, 64'd3, 64'd4, 32'd0, 32'd4, 1'b0));
    send(mk(OP_SYSTEM, 16'd2, 64'd3, 64'd4, 32'd1, 32'd1, 1'b1));
    send(mk(OP_UNDEFINED, 16'hFFFF, '1, '1, '1, '1, 1'b1));
    send(mk(OP_DELETE, 16'hFFFF, 64'hDEAD_BEEF_0123_4567, 64'd1, 32'd1, 32'd1, 1'b1));
    send(mk(OP_DELETE, 16'hFFFE, 64'h0000_0000_0000_ABCD, 64'd1, 32'd1, 32'd1, 1'b1));
    send(mk(OP_DELETE, 16'hFFFD, '1, 64'd1, 32'd1, 32'd1, 1'b1));
    drain();

    set_markers(16'd0, 16'd1, 16'd15);
    random_phase(475, 1'b0);
    drain();
    set_markers(16'hFFFF, 16'd0, 16'd2);
    random_phase(475, 1'b1);
    drain();
    set_markers(16'd3, 16'hFFFF, 16'd0);
    random_phase(475, 1'b0);
    drain();
    set_markers(16'hFFFD, 16'hFFFE, 16'hFFFF);
    random_phase(475, 1'b0);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/iost_pkg.sv
design/iost_table.sv
design/itch_order_state_tracker.sv
design/iost_checker.sv
test/iost_checker.sv
test/tb.sv
